/* hdl/symbol_intern_table_unit_macros.svh */
// Assertion macros for the sit_cell RTL of the symbol intern table
`ifndef SYMBOL_INTERN_TABLE_UNIT_MACROS_SVH
`define SYMBOL_INTERN_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define SIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define SIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SIT_ASSERT_IMP(lbl, ante, cons, msg)
`define SIT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/sit_pkg.sv */
// Package with sizes, codes and the chain word type of the symbol intern table
`timescale 1ns / 1ps

package sit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SYMBOL_LEN  = 64;
  localparam int KEY_MAX     = SYMBOL_LEN - 1;
  localparam int POS_W       = $clog2(SYMBOL_LEN);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  // One byte of a symbol as it travels down the cell chain
  typedef struct packed {
    logic       vld;
    logic [7:0] chr;
    logic       last;
    pos_t       pos;
    logic       ovf;
    logic       found;
    idx_t       idx;
    logic       is_new;
  } item_t;

endpackage

/* hdl/sit_cell.sv */
// One table entry: stored bytes, length and the running compare against a passing symbol
`timescale 1ns / 1ps
`include "symbol_intern_table_unit_macros.svh"

module sit_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  sit_pkg::idx_t cell_idx_i,
  input  sit_pkg::item_t item_i,
  output sit_pkg::item_t item_o
);

  logic [7:0]     mem_q [sit_pkg::SYMBOL_LEN];
  logic [7:0]     rd_q;
  sit_pkg::item_t a_q, b_q, b_d;
  logic           valid_q;
  sit_pkg::pos_t  len_q;
  logic           eq_q;

  logic           stored;
  logic           eq_now;
  logic           hit;
  logic           claim;
  sit_pkg::pos_t  pos_inc;

  // Compare the byte in stage A against the stored byte read for its position
  always_comb begin
    stored  = a_q.vld && !a_q.ovf;
    eq_now  = ((a_q.pos == '0) ? 1'b1 : eq_q) && (rd_q == a_q.chr);
    pos_inc = a_q.pos + sit_pkg::pos_t'(1);
    hit     = valid_q && stored && a_q.last && !a_q.found && eq_now && (len_q == pos_inc);
    claim   = !valid_q && stored && a_q.last && !a_q.found;
  end

  // Resolve the word handed to the next cell
  always_comb begin
    b_d = a_q;
    if (hit || claim) begin
      b_d.found  = 1'b1;
      b_d.idx    = cell_idx_i;
      b_d.is_new = claim;
    end
  end

  // Write bytes while the entry is free; read the stored byte for the incoming position
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      rd_q <= mem_q[item_i.pos];
      if (item_i.vld && !item_i.ovf && !valid_q && !claim) begin
        mem_q[item_i.pos] <= item_i.chr;
      end
    end
  end

  // Track the running match and take the entry on a claim
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      if (stored) begin
        eq_q <= eq_now;
      end
      if (claim) begin
        len_q <= pos_inc;
      end
    end
  end

  // Advance the two stages and hold the entry's valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      valid_q <= 1'b0;
    end else if (advance_i) begin
      a_q <= item_i;
      b_q <= b_d;
      if (claim) begin
        valid_q <= 1'b1;
      end
    end
  end

  assign item_o = b_q;

  `SIT_ASSERT_NXT(a_valid_sticky, valid_q, valid_q, "entry lost its valid flag")
  `SIT_ASSERT_NXT(a_found_kept, advance_i && a_q.vld && a_q.found, b_q.found, "match dropped")
  `SIT_ASSERT_NXT(a_claim_new, advance_i && claim, valid_q && b_q.is_new && b_q.found, "claim lost")
  `SIT_ASSERT_IMP(a_claim_hit, claim, !hit, "claim and match at once")

endmodule

/* hdl/symbol_intern_table_unit.sv */
// Top level of the symbol intern table: byte front end, cell chain and result register
//
// Usage: symbol bytes enter on the sym channel (sym_char_i, sym_last_i), one word per
// cycle; sym_last_i marks the final byte. For each final byte one result word leaves on
// the res channel: entry_index_o, is_new_o and status_o (ok, table full, too long).
// Other bytes yield no result.
// A word is accepted when its valid is high and its stall is low.
// Each table entry is one cell of a chain; every byte walks down the chain, two register
// stages per cell, compared in each cell against that entry's stored byte.
// Throughput: one byte per cycle while sym_stall_o is low, symbols back to back.
// A result is captured in the result register once its final byte has passed the input
// register and both register stages of every cell of the chain.
// Reset empties the table and the partial symbol; the entry byte stores need no clearing.
// While a result waits with res_stall_i high the whole chain holds and sym_stall_o is
// raised, so no word is lost.
`timescale 1ns / 1ps

module symbol_intern_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sym_valid_i,
  output logic       sym_stall_o,
  input  logic [7:0] sym_char_i,
  input  logic       sym_last_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [5:0] entry_index_o,
  output logic       is_new_o,
  output logic [1:0] status_o
);

  logic              advance;
  logic              sym_acc;
  sit_pkg::pos_t     key_len_q;
  logic              key_ovf_q;
  logic              byte_ovf;
  sit_pkg::item_t    in_q;
  sit_pkg::item_t    chain [sit_pkg::TABLE_DEPTH+1];
  sit_pkg::item_t    tail;
  logic              res_vld_q;
  logic [5:0]        res_idx_q;
  logic              res_new_q;
  sit_pkg::status_e  res_st_q;

  // Freeze everything while a result waits on a stalled receiver
  assign advance     = !(res_vld_q && res_stall_i);
  assign sym_stall_o = !advance;
  assign sym_acc     = sym_valid_i && advance;

  // A byte overflows once the key already holds its maximum length
  assign byte_ovf = key_ovf_q || (key_len_q == sit_pkg::pos_t'(sit_pkg::KEY_MAX));

  // Count key bytes; clear on the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      key_ovf_q <= 1'b0;
    end else if (sym_acc) begin
      if (sym_last_i) begin
        key_len_q <= '0;
        key_ovf_q <= 1'b0;
      end else if (byte_ovf) begin
        key_ovf_q <= 1'b1;
      end else begin
        key_len_q <= key_len_q + sit_pkg::pos_t'(1);
      end
    end
  end

  // Register the incoming word at the head of the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (advance) begin
      in_q.vld    <= sym_valid_i;
      in_q.chr    <= sym_char_i;
      in_q.last   <= sym_last_i;
      in_q.pos    <= key_len_q;
      in_q.ovf    <= byte_ovf;
      in_q.found  <= 1'b0;
      in_q.idx    <= '0;
      in_q.is_new <= 1'b0;
    end
  end

  assign chain[0] = in_q;

  // One cell per table entry
  for (genvar k = 0; k < sit_pkg::TABLE_DEPTH; k++) begin : g_cell
    sit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .cell_idx_i (sit_pkg::idx_t'(k)),
      .item_i     (chain[k]),
      .item_o     (chain[k+1])
    );
  end

  assign tail = chain[sit_pkg::TABLE_DEPTH];

  // Capture the result of each final byte at the chain's end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= tail.vld && tail.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (tail.ovf) begin
        res_idx_q <= '0;
        res_new_q <= 1'b0;
        res_st_q  <= sit_pkg::ST_TOO_LONG;
      end else if (tail.found) begin
        res_idx_q <= 6'(tail.idx);
        res_new_q <= tail.is_new;
        res_st_q  <= sit_pkg::ST_OK;
      end else begin
        res_idx_q <= '0;
        res_new_q <= 1'b0;
        res_st_q  <= sit_pkg::ST_FULL;
      end
    end
  end

  assign res_valid_o   = res_vld_q;
  assign entry_index_o = res_idx_q;
  assign is_new_o      = res_new_q;
  assign status_o      = res_st_q;

endmodule
